@@ src/bzmt_pkg.sv @@
`timescale 1ns / 1ps
package bzmt_pkg;
  localparam int MaxAreas   = 16;
  localparam int MaxObjects = 64;
  localparam int AW = $clog2(MaxAreas);
  localparam int CW = $clog2(MaxAreas + 1);
  localparam int OW = $clog2(MaxObjects);

  localparam logic [2:0] REQ_ADD_DEATH = 3'd0;
  localparam logic [2:0] REQ_ADD_SAFE  = 3'd1;
  localparam logic [2:0] REQ_REMOVE    = 3'd2;
  localparam logic [2:0] REQ_CLEAR     = 3'd3;
  localparam logic [2:0] REQ_REBUILD   = 3'd4;
  localparam logic [2:0] REQ_QUERY     = 3'd5;
  localparam logic [2:0] REQ_UPDATE    = 3'd6;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_INVALID      = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_NONE_REMOVED = 3'd3;
  localparam logic [2:0] ST_NO_INDEX     = 3'd4;
  localparam logic [2:0] ST_NOT_MOVED    = 3'd5;

  localparam logic [0:0] CFG_ZONE_MODE = 1'd0;
  localparam logic [0:0] CFG_THRESHOLD = 1'd1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic               box_valid;
    logic signed [23:0] box_min_x;
    logic signed [23:0] box_min_y;
    logic signed [23:0] box_min_z;
    logic signed [23:0] box_max_x;
    logic signed [23:0] box_max_y;
    logic signed [23:0] box_max_z;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [5:0]         object_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_safe;
    logic       state_changed;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] lo_x;
    logic signed [23:0] lo_y;
    logic signed [23:0] lo_z;
    logic signed [23:0] hi_x;
    logic signed [23:0] hi_y;
    logic signed [23:0] hi_z;
  } box_t;
endpackage

@@ src/bzmt_queue.sv @@
`timescale 1ns / 1ps
module bzmt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  bzmt_pkg::in_item_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output bzmt_pkg::in_item_t rd_data,
  output logic               not_empty
);
  import bzmt_pkg::*;
  in_item_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wr_en ? ~wp_r : wp_r;
    rp_nxt  = rd_en ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign rd_data   = mem_r[rp_r];
endmodule

@@ src/bzmt_engine.sv @@
`timescale 1ns / 1ps
module bzmt_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  bzmt_pkg::in_item_t  q_item,
  output logic                q_pop,
  input  logic                zone_mode,
  input  logic [23:0]         move_threshold,
  output logic                out_valid,
  input  logic                out_stall,
  output bzmt_pkg::out_item_t out_data
);
  import bzmt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // query walk
  localparam logic [2:0] S_REMD = 3'd2;  // compacting death table
  localparam logic [2:0] S_REMS = 3'd3;  // compacting safe table
  localparam logic [2:0] S_MOVE = 3'd4;  // distance check, squares
  localparam logic [2:0] S_MCMP = 3'd5;  // distance compare
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] st_r, st_nxt;
  in_item_t it_r;
  box_t death_r [MaxAreas];
  box_t safe_r  [MaxAreas];
  logic [CW-1:0] dcnt_r, scnt_r;
  logic index_ready_r;
  logic [CW-1:0] rd_r, wr_r;
  logic removed_r, hit_r;
  logic [OW-1:0] k_r;
  logic [71:0] pos_r [MaxObjects];
  logic [MaxObjects-1:0] pos_known_r, last_safe_r, safe_known_r;
  logic [71:0] old_pos_r;
  logic [47:0] sq_r [3];
  logic [47:0] thr_sq_r;
  logic update_r;
  out_item_t res_r;
  out_item_t out_r;
  logic ov_r;

  box_t key, cur, qbox;
  logic [CW-1:0] cnt_sel;
  logic [OW-1:0] qk;
  logic eq, has;
  logic signed [24:0] dx, dy, dz;
  logic [49:0] dsum;
  logic [2:0] first_st;
  logic out_take;

  assign key = '{it_r.box_min_x, it_r.box_min_y, it_r.box_min_z,
                 it_r.box_max_x, it_r.box_max_y, it_r.box_max_z};
  assign qbox = '{q_item.box_min_x, q_item.box_min_y, q_item.box_min_z,
                  q_item.box_max_x, q_item.box_max_y, q_item.box_max_z};
  assign qk = q_item.object_index[OW-1:0];
  assign cnt_sel = (st_r == S_REMD || (st_r == S_SCAN && !zone_mode)) ? dcnt_r : scnt_r;
  assign cur = (st_r == S_REMD || (st_r == S_SCAN && !zone_mode)) ?
               death_r[rd_r[AW-1:0]] : safe_r[rd_r[AW-1:0]];
  assign eq  = cur == key;
  assign has = it_r.point_x > cur.lo_x && it_r.point_x < cur.hi_x &&
               it_r.point_y > cur.lo_y && it_r.point_y < cur.hi_y &&
               it_r.point_z > cur.lo_z && it_r.point_z < cur.hi_z;
  assign dx = {old_pos_r[71], old_pos_r[71:48]} - {it_r.point_x[23], it_r.point_x};
  assign dy = {old_pos_r[47], old_pos_r[47:24]} - {it_r.point_y[23], it_r.point_y};
  assign dz = {old_pos_r[23], old_pos_r[23:0]}  - {it_r.point_z[23], it_r.point_z};
  assign dsum = {2'b0, sq_r[0]} + {2'b0, sq_r[1]} + {2'b0, sq_r[2]};

  assign q_pop = st_r == S_IDLE && q_valid;
  assign out_valid = ov_r;
  assign out_data = out_r;
  // output register frees the working result once it is copied
  assign out_take = st_r == S_OUT && (!ov_r || !out_stall);

  logic verdict, chg;
  assign verdict = zone_mode ? hit_r : !hit_r;
  assign chg = update_r && (!safe_known_r[k_r] || last_safe_r[k_r] != verdict);

  always_comb begin
    st_nxt = st_r;
    first_st = ST_OK;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        st_nxt = S_OUT;
        unique case (q_item.req_type)
          REQ_ADD_DEATH: begin
            if (!q_item.box_valid) first_st = ST_INVALID;
            else if (dcnt_r == CW'(MaxAreas)) first_st = ST_FULL;
          end
          REQ_ADD_SAFE: begin
            if (!q_item.box_valid) first_st = ST_INVALID;
            else if (scnt_r == CW'(MaxAreas)) first_st = ST_FULL;
          end
          REQ_REMOVE: begin
            if (!q_item.box_valid) first_st = ST_INVALID;
            else st_nxt = S_REMD;
          end
          REQ_QUERY: st_nxt = S_SCAN;
          REQ_UPDATE: begin
            if (!index_ready_r) first_st = ST_NO_INDEX;
            else if (pos_known_r[qk]) st_nxt = S_MOVE;
            else st_nxt = S_SCAN;
          end
          default: ;
        endcase
      end
      S_MOVE: st_nxt = S_MCMP;
      S_MCMP: st_nxt = (dsum > {2'b0, thr_sq_r}) ? S_SCAN : S_OUT;
      S_SCAN: if (rd_r >= cnt_sel || hit_r) st_nxt = S_OUT;
      S_REMD: if (rd_r >= cnt_sel) st_nxt = removed_r ? S_OUT : S_REMS;
      S_REMS: if (rd_r >= cnt_sel) st_nxt = S_OUT;
      S_OUT: if (!ov_r || !out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      dcnt_r <= '0;
      scnt_r <= '0;
      index_ready_r <= 1'b1;
      pos_known_r <= '0;
      last_safe_r <= '0;
      safe_known_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_take) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_item;
          res_r <= '{first_st, 1'b0, 1'b0};
          rd_r <= '0;
          wr_r <= '0;
          removed_r <= 1'b0;
          hit_r <= 1'b0;
          k_r <= qk;
          old_pos_r <= pos_r[qk];
          thr_sq_r <= move_threshold * move_threshold;
          update_r <= q_item.req_type == REQ_UPDATE;
          unique case (q_item.req_type)
            REQ_ADD_DEATH: if (first_st == ST_OK) begin
              death_r[dcnt_r[AW-1:0]] <= qbox;
              dcnt_r <= dcnt_r + 1'b1;
            end
            REQ_ADD_SAFE: if (first_st == ST_OK) begin
              safe_r[scnt_r[AW-1:0]] <= qbox;
              scnt_r <= scnt_r + 1'b1;
            end
            REQ_CLEAR: begin
              dcnt_r <= '0;
              scnt_r <= '0;
              index_ready_r <= 1'b0;
            end
            REQ_REBUILD: index_ready_r <= 1'b1;
            default: ;
          endcase
        end
        S_MOVE: begin
          sq_r[0] <= 48'(dx * dx);
          sq_r[1] <= 48'(dy * dy);
          sq_r[2] <= 48'(dz * dz);
        end
        S_MCMP: begin
          if (!(dsum > {2'b0, thr_sq_r})) res_r.status <= ST_NOT_MOVED;
        end
        S_SCAN: begin
          if (rd_r >= cnt_sel || hit_r) begin
            res_r <= '{res_r.status, verdict, chg};
            if (update_r) begin
              pos_r[k_r] <= {it_r.point_x, it_r.point_y, it_r.point_z};
              pos_known_r[k_r] <= 1'b1;
              if (chg) begin
                last_safe_r[k_r] <= verdict;
                safe_known_r[k_r] <= 1'b1;
              end
            end
          end else begin
            hit_r <= has;
            rd_r <= rd_r + 1'b1;
          end
        end
        S_REMD, S_REMS: begin
          if (rd_r >= cnt_sel) begin
            if (st_r == S_REMD) dcnt_r <= wr_r;
            else scnt_r <= wr_r;
            if (removed_r) begin
              index_ready_r <= 1'b1;
            end else if (st_r == S_REMD) begin
              rd_r <= '0;
              wr_r <= '0;
            end else begin
              res_r.status <= ST_NONE_REMOVED;
            end
          end else begin
            if (eq) removed_r <= 1'b1;
            else begin
              if (st_r == S_REMD) death_r[wr_r[AW-1:0]] <= cur;
              else safe_r[wr_r[AW-1:0]] <= cur;
              wr_r <= wr_r + 1'b1;
            end
            rd_r <= rd_r + 1'b1;
          end
        end
        S_OUT: if (out_take) out_r <= res_r;
        default: ;
      endcase
    end
  end
endmodule

@@ src/box_zone_membership_tracker.sv @@
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// in_     | in  | in_valid / in_stall   | bzmt_pkg::in_item_t
// out_    | out | out_valid / out_stall | bzmt_pkg::out_item_t
// cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// Adds, clear and rebuild go straight to the output state. Query walks one
// box a cycle; update runs the distance check first when the position is known.
// Remove compacts the death table, then the safe table only if no death box matched.
// Reset (rst_n low, synchronous) empties both tables and marks the index ready.
// A two-entry queue lets transactions be taken while the engine works or the
// output is stalled.
module box_zone_membership_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bzmt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bzmt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import bzmt_pkg::*;
  logic zone_mode_r;
  logic [23:0] thr_r;
  logic full, ne, pop;
  in_item_t qd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_mode_r <= 1'b0;
      thr_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ZONE_MODE) zone_mode_r <= cfg_data[0];
      else if (cfg_index == CFG_THRESHOLD) thr_r <= cfg_data;
    end
  end

  assign in_stall = full;

  bzmt_queue u_q (.clk, .rst_n, .wr_en(in_valid && !full), .wr_data(in_data),
    .full, .rd_en(pop), .rd_data(qd), .not_empty(ne));

  bzmt_engine u_eng (.clk, .rst_n, .q_valid(ne), .q_item(qd), .q_pop(pop),
    .zone_mode(zone_mode_r), .move_threshold(thr_r), .out_valid, .out_stall,
    .out_data);
endmodule

@@ src/bzmt_checker.sv @@
`timescale 1ns / 1ps
module bzmt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bzmt_pkg::out_item_t out_data
);
  import bzmt_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("in hold");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_NOT_MOVED) else $error("bad status");
  a_safe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> !out_data.is_safe && !out_data.state_changed)
    else $error("flags on error");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
endmodule

bind box_zone_membership_tracker bzmt_checker u_chk (.clk, .rst_n, .in_valid,
  .in_stall, .out_valid, .out_stall, .out_data);
